// File: rtl/flg_pkg.sv
// Package for the LFO-modulated flanger: sizes, register indexes, the queue entry type.
// No dependencies. Every other file of the block imports it.
package flg_pkg;

	// Delay line geometry.
	localparam int DELAY_DEPTH = 65536;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);

	// Sample and register widths.
	localparam int SAMPLE_W = 16;
	localparam int LFO_W    = 16;
	localparam int DELAY_W  = 24;
	localparam int FRAC_W   = 8;

	// Configuration port.
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = DELAY_W;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DELAY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_DELAY = CFG_IDX_W'(1);
	localparam logic [DELAY_W-1:0] MIN_DELAY_RST = DELAY_W'(225792);
	localparam logic [DELAY_W-1:0] MAX_DELAY_RST = DELAY_W'(564480);

	// Delay arithmetic: span is max - min, product is lfo * span, the exact
	// delay carries 24 fraction bits.
	localparam int SPAN_W  = DELAY_W + 1;
	localparam int PROD_W  = SPAN_W + LFO_W;
	localparam int D24_W   = PROD_W + 1;
	localparam int D8_W    = D24_W - 16;
	localparam int WHOLE_W = D8_W - FRAC_W;
	localparam int CMP_W   = ((WHOLE_W > ADDR_W) ? WHOLE_W : ADDR_W) + 1;

	// Queue between the front and the back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Words in flight at most: front stage, queue, back, output register.
	localparam int INFLIGHT_MAX = QUEUE_DEPTH + 3;
	localparam int INFLIGHT_W   = $clog2(INFLIGHT_MAX + 1);

	// One classified sample, ready to be carried out by the back.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [ADDR_W-1:0]          back;
		logic [FRAC_W-1:0]          frac;
	} flg_job_t;

endpackage

// File: rtl/flg_in_if.sv
// Input channel of the flanger: one audio sample and one LFO value per word.
// Depends on flg_pkg.
interface flg_in_if
	import flg_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] in_sample;
	logic signed [LFO_W-1:0]    lfo_value;

	modport source (output valid, output in_sample, output lfo_value, input ready);
	modport sink   (input valid, input in_sample, input lfo_value, output ready);
endinterface

// File: rtl/flg_out_if.sv
// Output channel of the flanger: one interpolated sample per word.
// Depends on flg_pkg.
interface flg_out_if
	import flg_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] out_sample;

	modport source (output valid, output out_sample, input ready);
	modport sink   (input valid, input out_sample, output ready);
endinterface

// File: rtl/flg_front.sv
// Front of the flanger: configuration registers, delay computation and clamping.
// Depends on flg_pkg; feeds flg_queue.
module flg_front
	import flg_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [SAMPLE_W-1:0] in_sample,
	input  logic signed [LFO_W-1:0]    lfo_value,
	output logic                      push_valid,
	input  logic                      push_ready,
	output flg_job_t                  push_job
);

	logic [DELAY_W-1:0] min_delay_q;
	logic [DELAY_W-1:0] max_delay_q;

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic signed [PROD_W-1:0]   prod_s1;
	logic [DELAY_W:0]           sum_s1;

	logic signed [SPAN_W-1:0] span;
	logic signed [PROD_W-1:0] prod;
	logic signed [D24_W-1:0]  d24;
	logic [D8_W-1:0]          d8;
	logic [CMP_W-1:0]         whole_ext;
	logic [CMP_W-1:0]         limit_ext;
	logic                     in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delay_q <= MIN_DELAY_RST;
			max_delay_q <= MAX_DELAY_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_MIN_DELAY) begin
				min_delay_q <= cfg_data[DELAY_W-1:0];
			end
			if (cfg_index == REG_MAX_DELAY) begin
				max_delay_q <= cfg_data[DELAY_W-1:0];
			end
		end
	end

	// Stage one: the one real multiplication, lfo times the span.
	always_comb begin
		span = $signed({1'b0, max_delay_q}) - $signed({1'b0, min_delay_q});
		prod = lfo_value * span;
	end

	assign in_ready = !valid_s1 || push_ready;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_s1 <= in_sample;
			prod_s1   <= prod;
			sum_s1    <= {1'b0, min_delay_q} + {1'b0, max_delay_q};
		end
	end

	// Stage two: min plus max times 2^15 plus the product gives the delay with
	// 24 fraction bits; keep 8, clamp below at zero and above at the end of the line.
	always_comb begin
		d24 = $signed({2'b00, sum_s1, 15'b0}) + $signed({prod_s1[PROD_W-1], prod_s1});
		if (d24 < 0) begin
			d8 = '0;
		end else begin
			d8 = d24[D24_W-1:16];
		end
		whole_ext = CMP_W'(d8[D8_W-1:FRAC_W]);
		limit_ext = CMP_W'(DELAY_DEPTH - 2);
		push_job.sample = sample_s1;
		if (whole_ext > limit_ext) begin
			push_job.back = limit_ext[ADDR_W-1:0];
			push_job.frac = '0;
		end else begin
			push_job.back = whole_ext[ADDR_W-1:0];
			push_job.frac = d8[FRAC_W-1:0];
		end
	end

	assign push_valid = valid_s1;

endmodule

// File: rtl/flg_queue.sv
// Short queue that decouples the flanger's front from its back.
// Depends on flg_pkg.
module flg_queue
	import flg_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push_valid,
	output logic     push_ready,
	input  flg_job_t push_job,
	output logic     pop_valid,
	input  logic     pop_ready,
	output flg_job_t pop_job
);

	flg_job_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

// File: rtl/flg_back.sv
// Back of the flanger: delay line memory, two reads, interpolation, output register.
// Depends on flg_pkg; takes jobs from flg_queue.
module flg_back
	import flg_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       pop_valid,
	output logic                       pop_ready,
	input  flg_job_t                   pop_job,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [SAMPLE_W-1:0] out_sample
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_READ = 2'd1;
	localparam logic [1:0] ST_MAC  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam int ACC_W = SAMPLE_W + FRAC_W + 2;
	localparam int RES_W = ACC_W - FRAC_W;

	logic [1:0]                 state_q;
	logic [ADDR_W-1:0]          wp_q;
	logic                       wrapped_q;
	logic [ADDR_W-1:0]          addr_a_q;
	logic [ADDR_W-1:0]          addr_b_q;
	logic                       valid_a_q;
	logic                       valid_b_q;
	logic [FRAC_W-1:0]          frac_q;
	logic signed [SAMPLE_W-1:0] rd_a_q;
	logic signed [SAMPLE_W-1:0] rd_b_q;
	logic signed [SAMPLE_W-1:0] a_q;
	logic signed [ACC_W-1:0]    prod_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_sample_q;

	logic signed [SAMPLE_W-1:0] mem [DELAY_DEPTH];

	logic [ADDR_W-1:0]          back1;
	logic [ADDR_W-1:0]          addr_a;
	logic [ADDR_W-1:0]          addr_b;
	logic                       take;
	logic                       rd_en;
	logic signed [SAMPLE_W-1:0] a_val;
	logic signed [SAMPLE_W-1:0] b_val;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [ACC_W-1:0]    acc;
	logic signed [RES_W-1:0]    res;
	logic signed [SAMPLE_W-1:0] res_sat;
	logic                       out_load;

	assign take      = (state_q == ST_IDLE) && pop_valid;
	assign pop_ready = (state_q == ST_IDLE);
	assign rd_en     = (state_q == ST_READ);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Positions back from the current write index, wrapping below zero.
	always_comb begin
		back1 = pop_job.back + 1'b1;
		if (pop_job.back <= wp_q) begin
			addr_a = wp_q - pop_job.back;
		end else begin
			addr_a = ADDR_W'((ADDR_W+1)'(wp_q) + (ADDR_W+1)'(DELAY_DEPTH)
				- (ADDR_W+1)'(pop_job.back));
		end
		if (back1 <= wp_q) begin
			addr_b = wp_q - back1;
		end else begin
			addr_b = ADDR_W'((ADDR_W+1)'(wp_q) + (ADDR_W+1)'(DELAY_DEPTH)
				- (ADDR_W+1)'(back1));
		end
	end

	// The line is never cleared: until the write index first wraps, only
	// the entries up to the current write index hold samples, the rest read
	// as silence.
	always_ff @(posedge clk) begin
		if (take) begin
			mem[wp_q] <= pop_job.sample;
		end
		if (rd_en) begin
			rd_a_q <= mem[addr_a_q];
			rd_b_q <= mem[addr_b_q];
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			addr_a_q  <= addr_a;
			addr_b_q  <= addr_b;
			valid_a_q <= wrapped_q || (pop_job.back <= wp_q);
			valid_b_q <= wrapped_q || (back1 <= wp_q);
			frac_q    <= pop_job.frac;
		end
		if (state_q == ST_MAC) begin
			a_q    <= a_val;
			prod_q <= ACC_W'($signed({1'b0, frac_q})) * ACC_W'(diff);
		end
	end

	always_comb begin
		a_val = valid_a_q ? rd_a_q : '0;
		b_val = valid_b_q ? rd_b_q : '0;
		diff  = (SAMPLE_W+1)'(b_val) - (SAMPLE_W+1)'(a_val);
		acc   = $signed({{2{a_q[SAMPLE_W-1]}}, a_q, {FRAC_W{1'b0}}}) + prod_q;
		res   = acc[ACC_W-1:FRAC_W];
		if (res > RES_W'(32767)) begin
			res_sat = 16'sh7fff;
		end else if (res < -RES_W'(32768)) begin
			res_sat = 16'sh8000;
		end else begin
			res_sat = res[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wp_q        <= '0;
			wrapped_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						state_q <= ST_READ;
						if (wp_q == ADDR_W'(DELAY_DEPTH - 1)) begin
							wp_q      <= '0;
							wrapped_q <= 1'b1;
						end else begin
							wp_q <= wp_q + 1'b1;
						end
					end
				end
				ST_READ: state_q <= ST_MAC;
				ST_MAC:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_sample_q <= res_sat;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;

endmodule

// File: rtl/lfo_modulated_flanger_unit.sv
// Top level of the LFO-modulated flanger: front, queue and back joined to the channels.
// Depends on flg_pkg, flg_in_if, flg_out_if, flg_front, flg_queue and flg_back.
//
//   channel   direction  word
//   in_ch     in         in_sample (Q1.15), lfo_value (Q1.15)
//   out_ch    out        out_sample (Q1.15, saturated)
//   cfg       in         cfg_we, cfg_index, cfg_data (min_delay = 0, max_delay = 1)
//
// In the back each word passes through write, read both taps, multiply, and
// sum and saturate; a new job is taken only once the last one has gone to
// the output register. The front registers each word and the queue holds
// two jobs, so the input keeps taking words while the output register waits
// on its sink.
// Reset is asynchronous and active low; the delay line itself is not swept,
// a wrap flag on the write index makes unwritten entries read as zero.
// The user must write configuration only while no word is in flight; not enforced.
module lfo_modulated_flanger_unit
	import flg_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	flg_in_if.sink                in_ch,
	flg_out_if.source             out_ch
);

	// Handshake between the front and the queue.
	logic     push_valid;
	logic     push_ready;
	flg_job_t push_job;

	// Handshake between the queue and the back.
	logic     pop_valid;
	logic     pop_ready;
	flg_job_t pop_job;

	// The front computes the fractional delay and its clamp per word.
	flg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_sample  (in_ch.in_sample),
		.lfo_value  (in_ch.lfo_value),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// The queue lets the front run ahead while the back is busy.
	flg_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// The back owns the delay line and produces the interpolated sample.
	flg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_sample (out_ch.out_sample)
	);

endmodule

// File: rtl/flg_checker.sv
// Port-level checks for the flanger, attached to the top level by bind.
// Depends on flg_pkg and lfo_modulated_flanger_unit.
module flg_checker
	import flg_pkg::*;
(
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] out_sample
);

	logic [INFLIGHT_W-1:0] inflight_q;
	logic                  in_fire;
	logic                  out_fire;

	assign in_fire  = in_valid && in_ready;
	assign out_fire = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else if (in_fire && !out_fire) begin
			inflight_q <= inflight_q + 1'b1;
		end else if (out_fire && !in_fire) begin
			inflight_q <= inflight_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_sample))
		else $error("output word changed while stalled");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != '0)
		else $error("output word shown with no input word outstanding");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> inflight_q < INFLIGHT_W'(INFLIGHT_MAX))
		else $error("input taken with every stage already full");

endmodule

bind lfo_modulated_flanger_unit flg_checker u_flg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_sample (out_ch.out_sample)
);
